// File: hw/rtl/ite_pkg.sv
// Shared constants and types for the IMU temperature noise estimator.
package ite_pkg;

  // Step clamp limits in microseconds
  localparam logic [19:0] StepMin = 20'd100;
  localparam logic [19:0] StepMax = 20'd1000000;

  // Temperature: floor((256*raw + 3179741 + 340*16384) / 340) - 16384
  localparam logic signed [25:0] TempBias   = 26'sd8750301;
  localparam logic [23:0]        TempRecip  = 24'd12632257;  // ceil(2^30 / 85)
  localparam int                 TempShift  = 30;
  localparam logic signed [16:0] TempOffset = 17'sd16384;

  // Window and fixed-point formats
  localparam int WindowDepth = 64;
  localparam int PosW   = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int FillW  = $clog2(WindowDepth + 1);
  localparam int InstW  = 40;
  localparam int VarW   = 40;
  localparam int SumW   = InstW + FillW;
  localparam int DvsW   = 43;
  localparam int SqW    = 76;
  localparam int DivSteps = 40;
  localparam logic [16:0] ScaleDen = 17'd115600;

  // Item queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic signed [15:0] r0;
    logic signed [15:0] r1;
    logic signed [15:0] r2;
    logic [19:0]        h1;
    logic [19:0]        h2;
    logic               steady;
    logic signed [16:0] temp;
  } item_t;

endpackage

// File: hw/rtl/ite_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ite_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ite_front.sv
// Front end: accepts samples, clamps the step, converts temperature, keeps history.
module ite_front import ite_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] temp_raw_i,
  input  logic [19:0]        step_us_i,
  input  logic               q_full_i,
  output logic               push_o,
  output item_t              item_o
);

  logic signed [15:0] r1_q, r2_q;
  logic [19:0]        h1_q;
  logic [1:0]         cnt_q;
  logic [19:0]        h2;
  logic signed [25:0] m_biased;
  logic [22:0]        m_quarter;
  logic [46:0]        temp_prod;
  logic [15:0]        temp_quot;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Clamp the step
  always_comb begin
    h2 = step_us_i;
    if (step_us_i < StepMin) begin
      h2 = StepMin;
    end else if (step_us_i > StepMax) begin
      h2 = StepMax;
    end
  end

  // Temperature by reciprocal multiply on a positive biased value
  assign m_biased  = {{2{temp_raw_i[15]}}, temp_raw_i, 8'h00} + TempBias;
  assign m_quarter = m_biased[24:2];
  assign temp_prod = {24'h0, m_quarter} * {23'h0, TempRecip};
  assign temp_quot = temp_prod[TempShift+15:TempShift];

  // Classify and build the queue beat
  always_comb begin
    item_o.r0     = r1_q;
    item_o.r1     = r2_q;
    item_o.r2     = temp_raw_i;
    item_o.h1     = h1_q;
    item_o.h2     = h2;
    item_o.steady = (cnt_q == 2'd2) || (cnt_q == 2'd3);
    item_o.temp   = $signed({1'b0, temp_quot}) - TempOffset;
  end

  // Advance sample history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_q  <= '0;
      r2_q  <= '0;
      h1_q  <= '0;
      cnt_q <= '0;
    end else if (push_o) begin
      r1_q <= r2_q;
      r2_q <= temp_raw_i;
      h1_q <= h2;
      if (cnt_q != 2'd3) begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/ite_queue.sv
// Short item queue between the front and back ends.
module ite_queue import ite_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  full_o,
  output logic  empty_o
);

  item_t            ent_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = cnt_q == QCntW'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign item_o  = ent_q[rd_ptr_q];

  // Store pushed beats
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= item_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/ite_back.sv
// Back end: stencil, squared difference, window sum and variance with one shared divider.
module ite_back import ite_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  item_t              item_i,
  output logic               pop_o,
  input  logic [VarW-1:0]    min_variance_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] temperature_q8_o,
  output logic [VarW-1:0]    variance_q16_o
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StMul   = 7'b0000010,
    StDiv   = 7'b0000100,
    StRing  = 7'b0001000,
    StUpd   = 7'b0010000,
    StScale = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  typedef enum logic [3:0] {
    MsR0 = 4'd0, MsR1 = 4'd1, MsR2 = 4'd2,
    MsH1 = 4'd3, MsHs = 4'd4, MsH2 = 4'd5,
    MsBb = 4'd6, MsAb = 4'd7, MsAa = 4'd8
  } mul_step_e;

  state_e             state_q, state_d;
  mul_step_e          step_q, step_d;
  logic [5:0]         cnt_q, cnt_d;
  item_t              item_q;
  logic signed [38:0] num_q, num_d;
  logic [DvsW-1:0]    den_q, den_d;
  logic [SqW-1:0]     sq_q, sq_d;
  logic [DvsW-1:0]    rem_q, rem_d;
  logic [InstW-1:0]   lo_q, lo_d;
  logic [DvsW-1:0]    dvs_q, dvs_d;
  logic               div_sel_q, div_sel_d;
  logic [VarW-1:0]    var_q, var_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic               out_valid_q, out_valid_d;
  logic signed [16:0] out_temp_q;
  logic [VarW-1:0]    out_var_q;
  logic               out_load;

  logic signed [21:0] mul_a, mul_b;
  logic signed [43:0] prod;
  logic [37:0]        mag;
  logic [20:0]        h_sum;
  logic [DvsW:0]      rem2, diff;
  logic               ge;
  logic               win_full;
  logic               ram_we, ram_re;
  logic [InstW-1:0]   ram_rdata;
  logic [InstW-1:0]   old_inst;

  assign mag      = num_q[38] ? 38'(-num_q) : num_q[37:0];
  assign h_sum    = {1'b0, item_q.h1} + {1'b0, item_q.h2};
  assign win_full = fill_q == FillW'(WindowDepth);
  assign old_inst = win_full ? ram_rdata : '0;
  assign prod     = mul_a * mul_b;

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == StScale) begin
      mul_a = {{(22 - FillW){1'b0}}, fill_q};
      mul_b = {5'h0, ScaleDen};
    end else begin
      case (step_q)
        MsR0: begin mul_a = {{6{item_q.r0[15]}}, item_q.r0}; mul_b = {2'b0, item_q.h2}; end
        MsR1: begin mul_a = {{6{item_q.r1[15]}}, item_q.r1}; mul_b = {1'b0, h_sum}; end
        MsR2: begin mul_a = {{6{item_q.r2[15]}}, item_q.r2}; mul_b = {2'b0, item_q.h1}; end
        MsH1: begin mul_a = {2'b0, item_q.h1}; mul_b = {2'b0, item_q.h1}; end
        MsHs: begin mul_a = {1'b0, h_sum}; mul_b = {1'b0, h_sum}; end
        MsH2: begin mul_a = {2'b0, item_q.h2}; mul_b = {2'b0, item_q.h2}; end
        MsBb: begin mul_a = {3'b0, mag[18:0]}; mul_b = {3'b0, mag[18:0]}; end
        MsAb: begin mul_a = {3'b0, mag[37:19]}; mul_b = {3'b0, mag[18:0]}; end
        MsAa: begin mul_a = {3'b0, mag[37:19]}; mul_b = {3'b0, mag[37:19]}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // One restoring divider step
  assign rem2 = {rem_q, lo_q[InstW-1]};
  assign diff = rem2 - {1'b0, dvs_q};
  assign ge   = rem2 >= {1'b0, dvs_q};

  // Sequence one item
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    num_d       = num_q;
    den_d       = den_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    lo_d        = lo_q;
    dvs_d       = dvs_q;
    div_sel_d   = div_sel_q;
    var_d       = var_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      StIdle: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          if (item_i.steady) begin
            step_d  = MsR0;
            state_d = StMul;
          end else begin
            var_d   = min_variance_i;
            state_d = StDone;
          end
        end
      end
      StMul: begin
        step_d = mul_step_e'(step_q + 4'd1);
        case (step_q)
          MsR0: num_d = $signed(prod[38:0]);
          MsR1: num_d = num_q - $signed(prod[38:0]);
          MsR2: num_d = num_q + $signed(prod[38:0]);
          MsH1: den_d = prod[DvsW-1:0];
          MsHs: den_d = den_q + prod[DvsW-1:0];
          MsH2: den_d = den_q + prod[DvsW-1:0];
          MsBb: sq_d = {38'h0, prod[37:0]};
          MsAb: sq_d = sq_q + {18'h0, prod[37:0], 20'h0};
          MsAa: begin
            sq_d      = sq_q + {prod[37:0], 38'h0};
            rem_d     = sq_d[74:32];
            lo_d      = {sq_d[31:0], 8'h00};
            dvs_d     = den_q;
            div_sel_d = 1'b0;
            cnt_d     = '0;
            if (den_q == '0) begin
              lo_d    = '0;
              state_d = StRing;
            end else begin
              state_d = StDiv;
            end
          end
          default: state_d = StIdle;
        endcase
      end
      StDiv: begin
        rem_d = ge ? diff[DvsW-1:0] : rem2[DvsW-1:0];
        lo_d  = {lo_q[InstW-2:0], ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DivSteps - 1)) begin
          if (div_sel_q) begin
            var_d   = (lo_d >= min_variance_i) ? lo_d : min_variance_i;
            state_d = StDone;
          end else begin
            state_d = StRing;
          end
        end
      end
      StRing: begin
        ram_re  = 1'b1;
        state_d = StUpd;
      end
      StUpd: begin
        ram_we  = 1'b1;
        sum_d   = sum_q - SumW'(old_inst) + SumW'(lo_q);
        pos_d   = (pos_q == PosW'(WindowDepth - 1)) ? '0 : pos_q + 1'b1;
        if (!win_full) begin
          fill_d = fill_q + 1'b1;
        end
        state_d = StScale;
      end
      StScale: begin
        dvs_d     = prod[DvsW-1:0];
        rem_d     = DvsW'(sum_q >> 32);
        lo_d      = {sum_q[31:0], 8'h00};
        div_sel_d = 1'b1;
        cnt_d     = '0;
        state_d   = StDiv;
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= MsR0;
      cnt_q       <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      div_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      div_sel_q   <= div_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold datapath and output beat
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
    end
    num_q <= num_d;
    den_q <= den_d;
    sq_q  <= sq_d;
    rem_q <= rem_d;
    lo_q  <= lo_d;
    dvs_q <= dvs_d;
    var_q <= var_d;
    if (out_load) begin
      out_temp_q <= item_q.temp;
      out_var_q  <= var_q;
    end
  end

  ite_ram #(
    .Width(InstW),
    .Depth(WindowDepth)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q),
    .wdata_i(lo_q),
    .re_i   (ram_re),
    .raddr_i(pos_q),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign temperature_q8_o = out_temp_q;
  assign variance_q16_o   = out_var_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WindowDepth)) else $error("window fill beyond depth");
  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (sum_q == '0)) else $error("empty window with nonzero sum");
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (rem_q < dvs_q)) else $error("divider remainder out of range");
`endif

endmodule

// File: hw/rtl/imu_temp_noise_estimator.sv
// Top level of the IMU temperature noise estimator.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   temp_raw_i, step_us_i
//  out      output     out_valid_o / out_stall_i temperature_q8_o, variance_q16_o
//  cfg      input      cfg_we_i                  cfg_wdata_i (min_variance)
//
// A warm-up beat passes from the queue through StIdle and StDone to the output register.
// A steady beat runs 9 multiplier steps, two 40-step passes
// of the shared restoring divider, and ring memory read and write.
// Reset clears history, window and queue; ring contents are tracked by fill count.
// The 2-entry queue keeps accepting until full while the back end works or out is stalled.
module imu_temp_noise_estimator import ite_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] temp_raw_i,
  input  logic [19:0]        step_us_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] temperature_q8_o,
  output logic [VarW-1:0]    variance_q16_o,
  input  logic               cfg_we_i,
  input  logic [VarW-1:0]    cfg_wdata_i
);

  logic [VarW-1:0] min_var_q;
  logic            push, pop, q_full, q_empty;
  item_t           front_item, back_item;

  // Hold the variance floor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_var_q <= '0;
    end else if (cfg_we_i) begin
      min_var_q <= cfg_wdata_i;
    end
  end

  ite_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .temp_raw_i(temp_raw_i),
    .step_us_i (step_us_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .item_o    (front_item)
  );

  ite_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (back_item),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  ite_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .item_i          (back_item),
    .pop_o           (pop),
    .min_variance_i  (min_var_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .temperature_q8_o(temperature_q8_o),
    .variance_q16_o  (variance_q16_o)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the IMU temperature noise estimator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ite_pkg::*;

  typedef struct packed {
    logic signed [16:0] temp_q8;
    logic [39:0]        variance;
  } estimate_t;

  localparam int WatchLimit = 20000;
  localparam int SettleCycles = 300;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] temp_raw_i = '0;
  logic [19:0]        step_us_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [16:0] temperature_q8_o;
  logic [39:0]        variance_q16_o;
  logic               cfg_we_i = 1'b0;
  logic [39:0]        cfg_wdata_i = '0;

  // Predictor state
  logic [39:0]        floor_var;
  logic signed [15:0] hist [3];
  int                 seen;
  logic [19:0]        prev_step;
  bit                 has_prev;
  logic [47:0]        inst_ring [64];
  int                 ring_pos;
  int                 ring_fill;
  logic [63:0]        window_sum;

  estimate_t          pending_q[$];
  int                 errors = 0;
  int                 idle_cycles = 0;
  int                 gap_pct = 0;
  int                 stall_pct = 0;

  imu_temp_noise_estimator DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .temp_raw_i, .step_us_i,
    .out_valid_o, .out_stall_i, .temperature_q8_o, .variance_q16_o,
    .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Work out the result of one accepted sample and advance the predictor
  function automatic estimate_t estimate_sample(logic signed [15:0] raw, logic [19:0] step);
    estimate_t   e;
    longint      n, t, h1, h2, num;
    logic [63:0] mag, den;
    logic [127:0] sq, v;
    logic [47:0] inst;
    h2 = longint'((step < StepMin) ? StepMin : (step > StepMax) ? StepMax : step);
    n = longint'(raw) * 25600 + 64'sd317974120;
    t = (n >= 0) ? n / 34000 : -((-n + 33999) / 34000);
    e.temp_q8 = t[16:0];
    hist[0] = hist[1];
    hist[1] = hist[2];
    hist[2] = raw;
    if (seen < 3) seen++;
    if (seen < 3 || !has_prev) begin
      e.variance = floor_var;
    end else begin
      h1 = longint'(prev_step);
      num = longint'(hist[0]) * h2 - longint'(hist[1]) * (h1 + h2) + longint'(hist[2]) * h1;
      mag = (num < 0) ? -num : num;
      den = h1 * h1 + (h1 + h2) * (h1 + h2) + h2 * h2;
      sq = ({64'd0, mag} * {64'd0, mag}) << 8;
      inst = (den == 0) ? 48'd0 : 48'(sq / {64'd0, den});
      if (ring_fill < 64) ring_fill++;
      else window_sum -= inst_ring[ring_pos];
      inst_ring[ring_pos] = inst;
      window_sum += inst;
      ring_pos = (ring_pos + 1) % 64;
      v = ({64'd0, window_sum} * 256) / (ring_fill * 128'd115600);
      if (v > 128'hFF_FFFF_FFFF) v = 128'hFF_FFFF_FFFF;
      e.variance = (v[39:0] < floor_var) ? floor_var : v[39:0];
    end
    prev_step = 20'(h2);
    has_prev = 1'b1;
    return e;
  endfunction

  // Drive one beat; called and returns at a falling edge, valid left high
  task automatic send_sample(logic signed [15:0] raw, logic [19:0] step);
    bit taken;
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    temp_raw_i <= raw;
    step_us_i  <= step;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      if (!in_stall_o) begin
        taken = 1'b1;
        pending_q.push_back(estimate_sample(raw, step));
      end
    end
    @(negedge clk_i);
  endtask

  // Wait for all results, hold off, then write the variance floor
  task automatic set_floor(logic [39:0] value);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait (pending_q.size() == 0);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    floor_var = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random stall on the result side
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    estimate_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat temp=%0d var=%0d", $time,
                 temperature_q8_o, variance_q16_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (temperature_q8_o !== e.temp_q8) begin
          $display("%0t: temperature expected %0d got %0d", $time,
                   e.temp_q8, temperature_q8_o);
          errors++;
        end
        if (variance_q16_o !== e.variance) begin
          $display("%0t: variance expected %0d got %0d", $time,
                   e.variance, variance_q16_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Extremes of raw counts and steps, warm-up, out-of-range steps
  task automatic test_directed();
    send_sample(16'sd0, 20'd0);
    send_sample(-16'sd32768, 20'd99);
    send_sample(16'sd32767, 20'd100);
    send_sample(-16'sd32768, 20'd1000000);
    send_sample(16'sd32767, 20'd1000001);
    send_sample(-16'sd32768, 20'hFFFFF);
    send_sample(16'sd32767, 20'd100);
    send_sample(-16'sd1, 20'd1000000);
    send_sample(16'sd1, 20'd100);
    send_sample(16'sd0, 20'h55555);
    send_sample(-16'sd21846, 20'hAAAAA);
    send_sample(16'sd21845, 20'd0);
    repeat (4) send_sample(16'sd100, 20'd1000);
    set_floor(40'hFF_FFFF_FFFF);
    send_sample(16'sd3000, 20'd500);
    send_sample(-16'sd3000, 20'd500);
    send_sample(16'sd5, 20'd777);
  endtask

  // Mostly slow drift with noise, some wild swings and odd steps
  task automatic test_random(int count);
    logic signed [15:0] base;
    logic signed [15:0] raw;
    logic [19:0]        step;
    int                 mode;
    base = 16'($urandom);
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(9);
      if (mode < 6) begin
        raw = base + $signed(16'($urandom_range(0, 40))) - 16'sd20;
        base = base + $signed(16'($urandom_range(0, 6))) - 16'sd3;
      end else begin
        raw = 16'($urandom);
      end
      case ($urandom_range(9))
        0:       step = 20'($urandom);
        1:       step = 20'($urandom_range(0, 120));
        2:       step = 20'($urandom_range(999900, 1048575));
        3, 4:    step = 20'($urandom_range(100, 1000000));
        default: step = 20'($urandom_range(900, 1100));
      endcase
      send_sample(raw, step);
    end
  endtask

  task automatic test_idle_phases();
    set_floor(40'd0);
    gap_pct = 0;  stall_pct = 0;
    test_random(330);
    set_floor($urandom_range(0, 300));
    gap_pct = 49; stall_pct = 0;
    test_random(330);
    set_floor({8'd0, 32'($urandom)});
    gap_pct = 0;  stall_pct = 49;
    test_random(330);
    set_floor(40'hFF_FFFF_FFFF);
    gap_pct = 12; stall_pct = 12;
    test_random(150);
    set_floor(40'd1);
    test_random(180);
  endtask

  initial begin
    floor_var = '0;
    hist = '{default: '0};
    seen = 0;
    prev_step = '0;
    has_prev = 1'b0;
    ring_pos = 0;
    ring_fill = 0;
    window_sum = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_idle_phases();
    in_valid_i <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ite_pkg.sv
hw/rtl/ite_ram.sv
hw/rtl/ite_front.sv
hw/rtl/ite_queue.sv
hw/rtl/ite_back.sv
hw/rtl/imu_temp_noise_estimator.sv
tb/testbench.sv
